### hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths and payload types for the sphere-sphere push-out pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int CW  = 32;          // coordinate width
    localparam int RSW = CW;          // radius sum width
    localparam int MW  = CW + 1;      // |b - a| width
    localparam int SW  = 2 * CW + 2;  // sum of squares width
    localparam int LW  = SW / 2;      // square root width
    localparam int NW  = 2 * CW + 1;  // divide numerator width
    localparam int QW  = CW + 1;      // quotient width

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic [CW-2:0]        radius_a;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_pos;
        logic signed [CW-1:0] bz;
        logic [CW-2:0]        radius_b;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
    } out_t;

    // Side data carried alongside the square root
    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic [RSW-1:0]     r;
        logic               hit;
    } root_side_t;

    // Side data carried alongside the dividers
    typedef struct packed {
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [2:0]         neg;
        logic               hit;
        logic               zero;
    } div_side_t;

endpackage

### hdl/ssp_isqrt.sv
// ----------------------------------------------------------------------------
// ssp_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ssp_isqrt #(
    parameter int RootW = ssp_pkg::LW
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [2*RootW-1:0] radicand,
    output logic [RootW-1:0]   root
);
    localparam int RemW = RootW + 3;

    logic [2*RootW-1:0] rad_reg  [RootW];
    logic [RemW-1:0]    rem_reg  [RootW];
    logic [RootW-1:0]   root_reg [RootW];

    genvar i;
    generate
        for (i = 0; i < RootW; i++) begin : g_stage
            logic [2*RootW-1:0] rad_in;
            logic [RemW-1:0]    rem_in;
            logic [RemW-1:0]    rem_sh;
            logic [RemW-1:0]    trial;
            logic [RootW-1:0]   root_in;

            if (i == 0) begin : g_first
                assign rad_in  = radicand;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
            end

            assign rem_sh = {rem_in[RemW-3:0], rad_in[2*(RootW-1-i)+1 -: 2]};
            assign trial  = {1'b0, root_in, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[i] <= rad_in;
                    if (rem_sh >= trial) begin
                        rem_reg[i]  <= rem_sh - trial;
                        root_reg[i] <= {root_in[RootW-2:0], 1'b1};
                    end else begin
                        rem_reg[i]  <= rem_sh;
                        root_reg[i] <= {root_in[RootW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RootW-1];

endmodule

### hdl/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssp_div #(
    parameter int NumW = ssp_pkg::NW,
    parameter int DenW = ssp_pkg::LW,
    parameter int QuoW = ssp_pkg::QW
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic [QuoW-1:0] quo
);
    localparam int RemW = DenW + 1;

    logic [NumW-1:0] num_reg [QuoW];
    logic [DenW-1:0] den_reg [QuoW];
    logic [RemW-1:0] rem_reg [QuoW];
    logic [QuoW-1:0] quo_reg [QuoW];

    genvar j;
    generate
        for (j = 0; j < QuoW; j++) begin : g_stage
            logic [NumW-1:0] num_in;
            logic [DenW-1:0] den_in;
            logic [RemW-1:0] rem_in;
            logic [QuoW-1:0] quo_in;
            logic [RemW-1:0] rem_sh;

            if (j == 0) begin : g_first
                assign num_in = num;
                assign den_in = den;
                assign rem_in = RemW'(num[NumW-1:QuoW]);
                assign quo_in = '0;
            end else begin : g_next
                assign num_in = num_reg[j-1];
                assign den_in = den_reg[j-1];
                assign rem_in = rem_reg[j-1];
                assign quo_in = quo_reg[j-1];
            end

            assign rem_sh = {rem_in[RemW-2:0], num_in[QuoW-1-j]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[j] <= num_in;
                    den_reg[j] <= den_in;
                    if (rem_sh >= {1'b0, den_in}) begin
                        rem_reg[j] <= rem_sh - {1'b0, den_in};
                        quo_reg[j] <= {quo_in[QuoW-2:0], 1'b1};
                    end else begin
                        rem_reg[j] <= rem_sh;
                        quo_reg[j] <= {quo_in[QuoW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QuoW-1];

endmodule

### hdl/sphere_sphere_pushout.sv
// ----------------------------------------------------------------------------
// sphere_sphere_pushout
// Sphere-sphere overlap test; on contact pushes B's centre out to touching.
// ----------------------------------------------------------------------------
//  channel | ports                     | payload
//  --------+---------------------------+--------------------------------------
//  input   | s_valid, s_ready, s_data  | ssp_pkg::in_t  (two centres, radii)
//  result  | m_valid, m_ready, m_data  | ssp_pkg::out_t (hit, pushed centre)
//
// One transfer in per cycle while no result is held; one result per input, in order.
// The root pipeline (one bit per stage, LW stages) and the divider pipeline
// (one quotient bit per stage, QW stages) set the depth.
// aresetn (synchronous) clears the valid bits only.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module sphere_sphere_pushout (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ssp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ssp_pkg::out_t m_data
);
    import ssp_pkg::*;

    localparam logic signed [CW+1:0] SAT_MAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] SAT_MIN = {3'b111, {(CW-1){1'b0}}};

    // global advance: every stage moves unless the output is held
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---- stage 0: differences and radius sum ----
    logic                v0_reg;
    logic [2:0][CW-1:0]  a0_reg, b0_reg;
    logic [2:0][CW:0]    d0_reg;
    logic [RSW-1:0]      r0_reg;
    logic [2:0][CW-1:0]  a_in, b_in;

    assign a_in = {s_data.az, s_data.ay, s_data.ax};
    assign b_in = {s_data.bz, s_data.by_pos, s_data.bx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a0_reg <= a_in;
            b0_reg <= b_in;
            r0_reg <= RSW'(s_data.radius_a) + RSW'(s_data.radius_b);
            for (int k = 0; k < 3; k++) begin
                d0_reg[k] <= {b_in[k][CW-1], b_in[k]} - {a_in[k][CW-1], a_in[k]};
            end
        end
    end

    // ---- stage 1: magnitudes, squares, squared radius sum ----
    logic                  v1_reg;
    logic [2:0][CW-1:0]    a1_reg, b1_reg;
    logic [2:0][MW-1:0]    mag1_reg;
    logic [2:0]            neg1_reg;
    logic [2:0][SW-1:0]    sq1_reg;
    logic [2*RSW-1:0]      rr1_reg;
    logic [RSW-1:0]        r1_reg;
    logic [2:0][MW-1:0]    mag0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag0[k] = d0_reg[k][CW] ? MW'(-d0_reg[k]) : MW'(d0_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            r1_reg  <= r0_reg;
            rr1_reg <= r0_reg * r0_reg;
            for (int k = 0; k < 3; k++) begin
                mag1_reg[k] <= mag0[k];
                neg1_reg[k] <= d0_reg[k][CW];
                sq1_reg[k]  <= SW'(mag0[k] * mag0[k]);
            end
        end
    end

    // ---- stage 2: sum of squares and overlap test ----
    logic        v2_reg;
    logic [SW-1:0] s2_reg;
    root_side_t  side2_reg;
    logic [SW-1:0] s1_sum;

    assign s1_sum = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg        <= s1_sum;
            side2_reg.a   <= a1_reg;
            side2_reg.b   <= b1_reg;
            side2_reg.mag <= mag1_reg;
            side2_reg.neg <= neg1_reg;
            side2_reg.r   <= r1_reg;
            side2_reg.hit <= s1_sum <= SW'(rr1_reg);
        end
    end

    // ---- square root, with side data delayed to match ----
    logic [LW-1:0] root;
    logic          vr_reg [LW];
    root_side_t    sr_reg [LW];

    ssp_isqrt #(.RootW(LW)) u_isqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (s2_reg),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LW; i++) begin
                vr_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vr_reg[0] <= v2_reg;
            for (int i = 1; i < LW; i++) begin
                vr_reg[i] <= vr_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sr_reg[0] <= side2_reg;
            for (int i = 1; i < LW; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    // ---- stage 3: |d| * R ----
    logic               v3_reg;
    logic [2:0][NW-1:0] num3_reg;
    logic [LW-1:0]      len3_reg;
    div_side_t          side3_reg;
    root_side_t         sr_last;

    assign sr_last = sr_reg[LW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= vr_reg[LW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len3_reg       <= root;
            side3_reg.a    <= sr_last.a;
            side3_reg.b    <= sr_last.b;
            side3_reg.neg  <= sr_last.neg;
            side3_reg.hit  <= sr_last.hit;
            side3_reg.zero <= root == '0;
            for (int k = 0; k < 3; k++) begin
                num3_reg[k] <= NW'(sr_last.mag[k] * sr_last.r);
            end
        end
    end

    // ---- stage 4: rounding offset len/2 ----
    logic               v4_reg;
    logic [2:0][NW-1:0] num4_reg;
    logic [LW-1:0]      len4_reg;
    div_side_t          side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            len4_reg  <= len3_reg;
            side4_reg <= side3_reg;
            for (int k = 0; k < 3; k++) begin
                num4_reg[k] <= num3_reg[k] + NW'(len3_reg >> 1);
            end
        end
    end

    // ---- three dividers, side data delayed to match ----
    logic [2:0][QW-1:0] quo;
    logic               vd_reg [QW];
    div_side_t          sd_reg [QW];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            ssp_div #(.NumW(NW), .DenW(LW), .QuoW(QW)) u_div (
                .aclk (aclk),
                .en   (adv),
                .num  (num4_reg[g]),
                .den  (len4_reg),
                .quo  (quo[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QW; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vd_reg[0] <= v4_reg;
            for (int i = 1; i < QW; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= side4_reg;
            for (int i = 1; i < QW; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // ---- stage 5: apply sign, add to A, saturate, select; output register ----
    logic                      v5_reg;
    out_t                      out5_reg;
    div_side_t                 sd_last;
    logic [2:0][CW-1:0]        coord;
    logic signed [CW+1:0]      qs, sum;

    assign sd_last = sd_reg[QW-1];

    always_comb begin
        qs  = '0;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            qs  = sd_last.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
            sum = $signed({{2{sd_last.a[k][CW-1]}}, sd_last.a[k]}) + qs;
            if (!sd_last.hit) begin
                coord[k] = sd_last.b[k];
            end else if (sd_last.zero) begin
                coord[k] = sd_last.a[k];
            end else if (sum > SAT_MAX) begin
                coord[k] = SAT_MAX[CW-1:0];
            end else if (sum < SAT_MIN) begin
                coord[k] = SAT_MIN[CW-1:0];
            end else begin
                coord[k] = sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= vd_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out5_reg.hit   <= sd_last.hit;
            out5_reg.out_x <= coord[0];
            out5_reg.out_y <= coord[1];
            out5_reg.out_z <= coord[2];
        end
    end

    assign m_valid = v5_reg;
    assign m_data  = out5_reg;

endmodule

### hdl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks for the push-out pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ssp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input ssp_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input ssp_pkg::out_t m_data
);
    // held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing comes out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is only back-pressured by a held result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // a held result blocks the input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // waiting input keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

endmodule

bind sphere_sphere_pushout ssp_checker u_ssp_checker (.*);
